@@ hw/rtl/wts_pkg.sv @@
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types, sizes and constants of the windowed temperature statistics.
// ----------------------------------------------------------------------------
package wts_pkg;

  localparam int unsigned WINDOW_DEPTH = 4096;
  localparam int unsigned RECENT_DEPTH = 10;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned COUNT_W  = 13;

  localparam int unsigned WIN_PTR_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned WIN_CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned WSUM_W    = WIN_CNT_W + 1;
  localparam int unsigned CMP_W     = (WIN_CNT_W > CFG_W) ? WIN_CNT_W : CFG_W;
  localparam int unsigned TOTAL_W   = SAMPLE_W + WIN_CNT_W;
  localparam int unsigned MAG_W     = TOTAL_W - 1;
  localparam int unsigned DIV_CNT_W = $clog2(MAG_W + 1);

  localparam int unsigned RECENT_PTR_W = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
  localparam int unsigned RECENT_CNT_W = $clog2(RECENT_DEPTH + 1);
  localparam int unsigned RSUM_W       = RECENT_CNT_W + INDEX_W;

  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 96;

  localparam logic signed [SAMPLE_W-1:0] LOW_RESET   = 16'sd5670;
  localparam logic signed [SAMPLE_W-1:0] HIGH_RESET  = -16'sd27315;
  localparam logic [CFG_W-1:0]           LIMIT_RESET = 13'd3600;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_ZERO,
    KIND_READ
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EVICT_RD,
    ST_EVICT_SUB,
    ST_WRITE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    kind_e                       kind;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [INDEX_W-1:0]          recent_index;
  } item_t;

  typedef struct packed {
    logic                        recent_valid;
    logic signed [SAMPLE_W-1:0]  recent_value;
    logic [COUNT_W-1:0]          window_count;
    logic signed [SAMPLE_W-1:0]  average_reading;
    logic signed [SAMPLE_W-1:0]  high_reading;
    logic signed [SAMPLE_W-1:0]  low_reading;
    logic signed [SAMPLE_W-1:0]  current_reading;
  } result_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

@@ hw/rtl/wts_front.sv @@
// ----------------------------------------------------------------------------
// wts_front
// Accepts input transactions and classifies them for the back end.
// ----------------------------------------------------------------------------
module wts_front (
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [wts_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           q_full_i,
  output logic                           push_o,
  output wts_pkg::item_t                 item_o
);

  logic signed [wts_pkg::SAMPLE_W-1:0] sample;

  assign sample        = s_axis_tdata[wts_pkg::SAMPLE_W-1:0];
  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

  always_comb begin
    item_o.sample       = sample;
    item_o.recent_index = s_axis_tdata[wts_pkg::SAMPLE_W +: wts_pkg::INDEX_W];
    if (s_axis_tuser) begin
      item_o.kind = wts_pkg::KIND_READ;
    end else if (sample == '0) begin
      // zero means a lost link: only the latest reading moves
      item_o.kind = wts_pkg::KIND_ZERO;
    end else begin
      item_o.kind = wts_pkg::KIND_SAMPLE;
    end
  end

endmodule

@@ hw/rtl/wts_queue.sv @@
// ----------------------------------------------------------------------------
// wts_queue
// Short FIFO of classified items between front and back end.
// ----------------------------------------------------------------------------
module wts_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wts_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output wts_pkg::item_t item_o
);

  wts_pkg::item_t              entry_q [wts_pkg::QUEUE_DEPTH];
  logic [wts_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [wts_pkg::QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [wts_pkg::QCNT_W-1:0]  count_q, count_d;
  logic                        do_pop;

  localparam logic [wts_pkg::QPTR_W-1:0] PtrLast = wts_pkg::QPTR_W'(wts_pkg::QUEUE_DEPTH - 1);

  assign full_o  = (count_q == wts_pkg::QCNT_W'(wts_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ hw/rtl/wts_div.sv @@
// ----------------------------------------------------------------------------
// wts_div
// Bit-serial signed by unsigned divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module wts_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [wts_pkg::TOTAL_W-1:0]  dividend_i,
  input  logic [wts_pkg::WIN_CNT_W-1:0]       divisor_i,
  output logic                                done_o,
  output logic signed [wts_pkg::SAMPLE_W-1:0] quotient_o
);

  localparam int unsigned RW = wts_pkg::WIN_CNT_W;
  localparam int unsigned MW = wts_pkg::MAG_W;

  logic                              busy_q, done_q;
  logic [wts_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [RW-1:0]                     rem_q, div_q;
  logic [MW-1:0]                     quo_q;
  logic                              neg_q;
  logic [wts_pkg::TOTAL_W-1:0]       abs_val;
  logic [RW:0]                       r_sh, diff;
  logic                              ge;
  logic [wts_pkg::SAMPLE_W-1:0]      q_lo;

  assign abs_val = dividend_i[wts_pkg::TOTAL_W-1] ? (-dividend_i) : dividend_i;
  assign r_sh    = {rem_q, quo_q[MW-1]};
  assign ge      = (r_sh >= {1'b0, div_q});
  assign diff    = r_sh - {1'b0, div_q};
  assign q_lo    = quo_q[wts_pkg::SAMPLE_W-1:0];

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (-q_lo) : q_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == wts_pkg::DIV_CNT_W'(MW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= abs_val[MW-1:0];
      div_q <= divisor_i;
      neg_q <= dividend_i[wts_pkg::TOTAL_W-1];
    end else if (busy_q) begin
      rem_q <= ge ? diff[RW-1:0] : r_sh[RW-1:0];
      quo_q <= {quo_q[MW-2:0], ge};
    end
  end

endmodule

@@ hw/rtl/wts_back.sv @@
// ----------------------------------------------------------------------------
// wts_back
// Executes queued items: statistics, window store, recent store and mean.
// ----------------------------------------------------------------------------
module wts_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wts_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          q_valid_i,
  input  wts_pkg::item_t                q_item_i,
  output logic                          q_pop_o,
  output wts_pkg::hs_t                  out_hs_o,
  input  logic                          out_ready_i,
  output wts_pkg::result_t              out_data_o
);

  localparam int unsigned SW = wts_pkg::SAMPLE_W;

  wts_pkg::state_e state_q, state_d;

  // control strobes
  logic mem_rd, mem_we, div_start, out_load;

  logic [wts_pkg::CFG_W-1:0]           limit_q;
  wts_pkg::item_t                      item_q;
  logic [1:0]                          evict_q;
  logic [1:0]                          n_evict;
  logic [wts_pkg::WIN_PTR_W-1:0]       head_q;
  logic [wts_pkg::WIN_CNT_W-1:0]       fill_q;
  logic signed [wts_pkg::TOTAL_W-1:0]  total_q;
  logic signed [SW-1:0]                latest_q, low_q, high_q, avg_q;
  logic [wts_pkg::RECENT_PTR_W-1:0]    rhead_q;
  logic [wts_pkg::RECENT_CNT_W-1:0]    rfill_q;
  logic signed [SW-1:0]                rval_q;
  logic                                rvalid_q;
  logic                                out_valid_q;
  wts_pkg::result_t                    out_data_q;

  logic signed [SW-1:0]                win_mem [wts_pkg::WINDOW_DEPTH];
  logic signed [SW-1:0]                rdata_q;
  logic signed [SW-1:0]                rec_q [wts_pkg::RECENT_DEPTH];

  logic [wts_pkg::CMP_W-1:0]           lim, fill_x;
  logic [wts_pkg::WSUM_W-1:0]          wsum;
  logic [wts_pkg::WIN_PTR_W-1:0]       wr_addr, head_inc;
  logic [wts_pkg::RSUM_W-1:0]          rw_sum, rr_sum, idx_x, rfill_x;
  logic [wts_pkg::RECENT_PTR_W-1:0]    rw_idx, rr_idx;
  logic                                rd_hit;
  logic                                div_done;
  logic signed [SW-1:0]                quotient;

  localparam logic [wts_pkg::WIN_PTR_W-1:0] WinLast =
    wts_pkg::WIN_PTR_W'(wts_pkg::WINDOW_DEPTH - 1);
  localparam logic [wts_pkg::RECENT_PTR_W-1:0] RecLast =
    wts_pkg::RECENT_PTR_W'(wts_pkg::RECENT_DEPTH - 1);

  // window limit clamped to 1 .. depth
  always_comb begin
    lim = wts_pkg::CMP_W'(limit_q);
    if (limit_q == '0) begin
      lim = wts_pkg::CMP_W'(1);
    end else if (wts_pkg::CMP_W'(limit_q) > wts_pkg::CMP_W'(wts_pkg::WINDOW_DEPTH)) begin
      lim = wts_pkg::CMP_W'(wts_pkg::WINDOW_DEPTH);
    end
    fill_x = wts_pkg::CMP_W'(fill_q);
    if (fill_x > lim) begin
      n_evict = 2'd2;
    end else if (fill_x == lim) begin
      n_evict = 2'd1;
    end else begin
      n_evict = 2'd0;
    end
  end

  // window addressing
  always_comb begin
    wsum = wts_pkg::WSUM_W'(head_q) + wts_pkg::WSUM_W'(fill_q);
    if (wsum >= wts_pkg::WSUM_W'(wts_pkg::WINDOW_DEPTH)) begin
      wsum = wsum - wts_pkg::WSUM_W'(wts_pkg::WINDOW_DEPTH);
    end
    wr_addr  = wsum[wts_pkg::WIN_PTR_W-1:0];
    head_inc = (head_q == WinLast) ? '0 : head_q + 1'b1;
  end

  // recent store addressing
  always_comb begin
    rfill_x = wts_pkg::RSUM_W'(rfill_q);
    idx_x   = wts_pkg::RSUM_W'(item_q.recent_index);
    rw_sum  = wts_pkg::RSUM_W'(rhead_q) + rfill_x;
    if (rw_sum >= wts_pkg::RSUM_W'(wts_pkg::RECENT_DEPTH)) begin
      rw_sum = rw_sum - wts_pkg::RSUM_W'(wts_pkg::RECENT_DEPTH);
    end
    rr_sum = wts_pkg::RSUM_W'(rhead_q) + idx_x;
    if (rr_sum >= wts_pkg::RSUM_W'(wts_pkg::RECENT_DEPTH)) begin
      rr_sum = rr_sum - wts_pkg::RSUM_W'(wts_pkg::RECENT_DEPTH);
    end
    // when the store is full the write slot is the head itself
    rw_idx = (rfill_q == wts_pkg::RECENT_CNT_W'(wts_pkg::RECENT_DEPTH)) ?
             rhead_q : rw_sum[wts_pkg::RECENT_PTR_W-1:0];
    rr_idx = rr_sum[wts_pkg::RECENT_PTR_W-1:0];
    rd_hit = (idx_x < rfill_x);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wts_pkg::ST_IDLE: begin
        if (q_valid_i) state_d = wts_pkg::ST_EVAL;
      end
      wts_pkg::ST_EVAL: begin
        if (item_q.kind != wts_pkg::KIND_SAMPLE) begin
          state_d = wts_pkg::ST_OUT;
        end else if (n_evict != 2'd0) begin
          state_d = wts_pkg::ST_EVICT_RD;
        end else begin
          state_d = wts_pkg::ST_WRITE;
        end
      end
      wts_pkg::ST_EVICT_RD:  state_d = wts_pkg::ST_EVICT_SUB;
      wts_pkg::ST_EVICT_SUB: begin
        state_d = (evict_q == 2'd1) ? wts_pkg::ST_WRITE : wts_pkg::ST_EVICT_RD;
      end
      wts_pkg::ST_WRITE:     state_d = wts_pkg::ST_DIV_GO;
      wts_pkg::ST_DIV_GO:    state_d = wts_pkg::ST_DIV_WAIT;
      wts_pkg::ST_DIV_WAIT: begin
        if (div_done) state_d = wts_pkg::ST_OUT;
      end
      wts_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = wts_pkg::ST_IDLE;
      end
      default: state_d = wts_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop_o   = 1'b0;
    mem_rd    = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      wts_pkg::ST_IDLE:     q_pop_o   = q_valid_i;
      wts_pkg::ST_EVICT_RD: mem_rd    = 1'b1;
      wts_pkg::ST_WRITE:    mem_we    = 1'b1;
      wts_pkg::ST_DIV_GO:   div_start = 1'b1;
      wts_pkg::ST_OUT:      out_load  = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wts_pkg::ST_IDLE;
      limit_q     <= wts_pkg::LIMIT_RESET;
      evict_q     <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      total_q     <= '0;
      latest_q    <= '0;
      low_q       <= wts_pkg::LOW_RESET;
      high_q      <= wts_pkg::HIGH_RESET;
      avg_q       <= '0;
      rhead_q     <= '0;
      rfill_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      case (state_q)
        wts_pkg::ST_EVAL: begin
          if (item_q.kind != wts_pkg::KIND_READ) begin
            latest_q <= item_q.sample;
          end
          if (item_q.kind == wts_pkg::KIND_SAMPLE) begin
            evict_q <= n_evict;
            if (rfill_q != wts_pkg::RECENT_CNT_W'(wts_pkg::RECENT_DEPTH)) begin
              rfill_q <= rfill_q + 1'b1;
            end else begin
              rhead_q <= (rhead_q == RecLast) ? '0 : rhead_q + 1'b1;
            end
            if (item_q.sample < low_q)  low_q  <= item_q.sample;
            if (item_q.sample > high_q) high_q <= item_q.sample;
          end
        end
        wts_pkg::ST_EVICT_SUB: begin
          total_q <= total_q - wts_pkg::TOTAL_W'(rdata_q);
          head_q  <= head_inc;
          fill_q  <= fill_q - 1'b1;
          evict_q <= evict_q - 1'b1;
        end
        wts_pkg::ST_WRITE: begin
          total_q <= total_q + wts_pkg::TOTAL_W'(item_q.sample);
          fill_q  <= fill_q + 1'b1;
        end
        wts_pkg::ST_DIV_WAIT: begin
          if (div_done) avg_q <= quotient;
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, memory and recent store
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
    if (mem_rd) begin
      rdata_q <= win_mem[head_q];
    end
    if (mem_we) begin
      win_mem[wr_addr] <= item_q.sample;
    end
    if (state_q == wts_pkg::ST_EVAL) begin
      rval_q   <= '0;
      rvalid_q <= 1'b0;
      if (item_q.kind == wts_pkg::KIND_SAMPLE) begin
        rec_q[rw_idx] <= item_q.sample;
      end else if (item_q.kind == wts_pkg::KIND_READ && rd_hit) begin
        rval_q   <= rec_q[rr_idx];
        rvalid_q <= 1'b1;
      end
    end
    if (out_load) begin
      out_data_q.current_reading <= latest_q;
      out_data_q.low_reading     <= low_q;
      out_data_q.high_reading    <= high_q;
      out_data_q.average_reading <= avg_q;
      out_data_q.window_count    <= wts_pkg::COUNT_W'(fill_q);
      out_data_q.recent_value    <= rval_q;
      out_data_q.recent_valid    <= rvalid_q;
    end
  end

  wts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_q),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_hs_o.valid = out_valid_q;
  assign out_hs_o.ready = out_ready_i;
  assign out_data_o     = out_data_q;

endmodule

@@ hw/rtl/windowed_temperature_statistics_unit.sv @@
// Processing: one item at a time in the back end. A read or a zero sample goes
//   straight from evaluation to the output register; a nonzero sample first does
//   0..2 window evictions, the window write and the bit-serial mean divider
//   (28 steps) before the output loads; each eviction reads the single-port window memory.
// Reset: rst_ni async low clears counters, totals and the queue; low/high load
//   5670/-27315, limit 3600. Window and recent stores are not cleared.
// ----------------------------------------------------------------------------
// windowed_temperature_statistics_unit
// Temperature statistics over a sliding window with min, max and recent log.
// ----------------------------------------------------------------------------
module windowed_temperature_statistics_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wts_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // sample[15:0], recent_index[19:16], zero fill
  input  logic [wts_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // command
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // current_reading[15:0], low_reading[31:16], high_reading[47:32],
  // average_reading[63:48], window_count[76:64], recent_value[92:77],
  // recent_valid[93], zero fill
  output logic [wts_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  logic             push, q_full, q_valid, q_pop;
  wts_pkg::item_t   in_item, q_item;
  wts_pkg::hs_t     out_hs;
  wts_pkg::result_t result;

  wts_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (in_item)
  );

  wts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  wts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_hs_o    (out_hs),
    .out_ready_i (m_axis_tready),
    .out_data_o  (result)
  );

  assign m_axis_tvalid = out_hs.valid;
  assign m_axis_tdata  = wts_pkg::OUT_TDATA_W'(result);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the windowed temperature statistics unit. Sends
// samples and recent-log reads over the input stream, predicts every result
// from a local copy of the window, min/max and recent log, and compares each
// output transaction field by field while both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import wts_pkg::*;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam int unsigned STALL_LIMIT  = 4000;  // quiet cycles before giving up
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS  = 105;
  localparam int unsigned MAX_PRINTS   = 100;

  localparam logic [CFG_W-1:0] PHASE_LIMITS [12] = '{
    13'd0, 13'd3, 13'd1, 13'd8191, 13'd2, 13'd25,
    13'd4096, 13'd4097, 13'd7, 13'd3600, 13'd1, 13'd12
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // sample[15:0], recent_index[19:16], zero fill
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // command
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // current_reading[15:0], low_reading[31:16], high_reading[47:32],
  // average_reading[63:48], window_count[76:64], recent_value[92:77],
  // recent_valid[93], zero fill
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  windowed_temperature_statistics_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Statistics tracked by the bench
  logic signed [SAMPLE_W-1:0] win_mem [WINDOW_DEPTH];
  logic [WIN_PTR_W-1:0]       win_head;
  logic [WIN_CNT_W-1:0]       win_fill;
  logic signed [TOTAL_W-1:0]  win_sum;
  logic signed [SAMPLE_W-1:0] cur_temp;
  logic signed [SAMPLE_W-1:0] min_temp;
  logic signed [SAMPLE_W-1:0] max_temp;
  logic signed [SAMPLE_W-1:0] log_mem [RECENT_DEPTH];
  logic [RECENT_PTR_W-1:0]    log_head;
  logic [RECENT_CNT_W-1:0]    log_fill;
  logic [CFG_W-1:0]           avg_limit;

  result_t     pending_stats[$];
  int unsigned error_count = 0;

  // Stream control knobs, changed by the tests
  int unsigned burst_left = 0;
  int unsigned gap_max    = 4;   // 0: sender offers back to back
  int unsigned stall_pct  = 30;  // 0: receiver always ready
  bit          holding    = 1'b0;
  int unsigned rx_run     = 0;
  event        hold_ev;

  function automatic void clear_stats();
    win_head  = '0;
    win_fill  = '0;
    win_sum   = '0;
    cur_temp  = '0;
    min_temp  = LOW_RESET;
    max_temp  = HIGH_RESET;
    log_head  = '0;
    log_fill  = '0;
    avg_limit = LIMIT_RESET;
  endfunction

  function automatic void drop_oldest();
    if (win_fill != 0) begin
      win_sum  = win_sum - win_mem[win_head];
      win_head = win_head + 1'b1;  // power-of-two depth, wraps by itself
      win_fill = win_fill - 1'b1;
    end
  endfunction

  function automatic void add_reading(logic signed [SAMPLE_W-1:0] t);
    int unsigned          lim;
    logic [WIN_PTR_W-1:0] slot;
    cur_temp = t;
    if (t == 0) return;  // lost link
    log_mem[(log_head + log_fill) % RECENT_DEPTH] = t;
    if (log_fill < RECENT_DEPTH) begin
      log_fill = log_fill + 1'b1;
    end else begin
      log_head = RECENT_PTR_W'((log_head + 1) % RECENT_DEPTH);
    end
    lim = avg_limit;
    if (lim == 0) lim = 1;
    if (lim > WINDOW_DEPTH) lim = WINDOW_DEPTH;
    // above the limit the window shrinks by one per sample
    if (win_fill > lim) begin
      drop_oldest();
      drop_oldest();
    end else if (win_fill == lim) begin
      drop_oldest();
    end
    slot = win_head + win_fill[WIN_PTR_W-1:0];
    win_mem[slot] = t;
    win_fill = win_fill + 1'b1;
    win_sum  = win_sum + t;
    if (t < min_temp) min_temp = t;
    if (t > max_temp) max_temp = t;
  endfunction

  function automatic result_t predict_stats(logic cmd, logic signed [SAMPLE_W-1:0] t,
                                            logic [INDEX_W-1:0] idx);
    result_t r;
    longint  total;
    r = '0;
    if (cmd == CMD_SAMPLE) begin
      add_reading(t);
    end else if (idx < log_fill) begin
      r.recent_value = log_mem[(log_head + idx) % RECENT_DEPTH];
      r.recent_valid = 1'b1;
    end
    r.current_reading = cur_temp;
    r.low_reading     = min_temp;
    r.high_reading    = max_temp;
    if (win_fill != 0) begin
      total = win_sum;
      r.average_reading = SAMPLE_W'(total / longint'(win_fill));
    end
    r.window_count = win_fill;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("%0t ns mismatch %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Output check first, then prediction of the input accepted at the same edge
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (pending_stats.size() == 0) begin
          report_mismatch("result with none pending", 0, 0);
        end else begin
          want = pending_stats.pop_front();
          if (got.current_reading !== want.current_reading)
            report_mismatch("current_reading", got.current_reading, want.current_reading);
          if (got.low_reading !== want.low_reading)
            report_mismatch("low_reading", got.low_reading, want.low_reading);
          if (got.high_reading !== want.high_reading)
            report_mismatch("high_reading", got.high_reading, want.high_reading);
          if (got.average_reading !== want.average_reading)
            report_mismatch("average_reading", got.average_reading, want.average_reading);
          if (got.window_count !== want.window_count)
            report_mismatch("window_count", got.window_count, want.window_count);
          if (got.recent_value !== want.recent_value)
            report_mismatch("recent_value", got.recent_value, want.recent_value);
          if (got.recent_valid !== want.recent_valid)
            report_mismatch("recent_valid", got.recent_valid, want.recent_valid);
        end
      end
      if (cfg_we_i) avg_limit = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        pending_stats.push_back(predict_stats(s_axis_tuser, s_axis_tdata[SAMPLE_W-1:0],
                                              s_axis_tdata[SAMPLE_W+INDEX_W-1:SAMPLE_W]));
    end
  end

  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random ready/stall runs, overridden by a long hold-off
  always @(negedge clk_i) begin
    if (holding) begin
      m_axis_tready <= 1'b0;
    end else if (rx_run != 0) begin
      rx_run = rx_run - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      m_axis_tready <= 1'b0;
      rx_run = $urandom_range(8);
    end else begin
      m_axis_tready <= 1'b1;
      rx_run = $urandom_range(16);
    end
  end

  always begin
    @(hold_ev);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    holding = 1'b0;
  end

  task automatic send_item(logic cmd, logic signed [SAMPLE_W-1:0] t, logic [INDEX_W-1:0] idx);
    if (gap_max != 0 && burst_left == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(gap_max, 1)) @(negedge clk_i);
      burst_left = $urandom_range(12, 1);
    end else begin
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_TDATA_W-SAMPLE_W-INDEX_W){1'b0}}, idx, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (burst_left != 0) burst_left--;
  endtask

  task automatic wait_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_stats.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] v);
    wait_results();
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_temp(bit allow_zero);
    logic signed [SAMPLE_W-1:0] t;
    case ($urandom_range(11))
      0:          t = 16'sh7FFF;
      1:          t = 16'sh8000;
      2:          t = $urandom_range(1) ? 16'sd1 : -16'sd1;
      3:          t = '0;
      4, 5, 6, 7: t = SAMPLE_W'($urandom_range(10000)) - 16'sd4000;  // -40 .. 60 degC
      default:    t = SAMPLE_W'($urandom());
    endcase
    if (!allow_zero && t == 0) t = 16'sd1;
    return t;
  endfunction

  task automatic test_reset_state();
    send_item(CMD_READ, 16'sh7FFF, 4'd0);
    send_item(CMD_READ, 16'sh8000, 4'd9);
    send_item(CMD_READ, 16'sh0000, 4'd15);
    send_item(CMD_SAMPLE, 16'sd0, 4'd5);  // only the latest reading moves
  endtask

  task automatic test_extremes();
    send_item(CMD_SAMPLE, 16'sh7FFF, 4'hF);
    send_item(CMD_SAMPLE, 16'sh8000, 4'h0);
    send_item(CMD_SAMPLE, -16'sd1, 4'h0);
    send_item(CMD_SAMPLE, 16'sd1, 4'h0);
    send_item(CMD_SAMPLE, 16'sd0, 4'h0);
    send_item(CMD_READ, 16'sd0, 4'd3);
    send_item(CMD_READ, 16'sd0, 4'd4);  // just past the fill
  endtask

  task automatic test_recent_wrap();
    // more nonzero samples than the log holds, so the oldest roll off
    repeat (7) send_item(CMD_SAMPLE, pick_temp(1'b0), 4'd0);
    send_item(CMD_READ, 16'sh7FFF, 4'd0);
    send_item(CMD_READ, 16'sd0, 4'd9);
    send_item(CMD_READ, 16'sd0, 4'd10);
  endtask

  task automatic test_window_limit();
    write_limit(13'd1);
    repeat (2) send_item(CMD_SAMPLE, pick_temp(1'b0), 4'd0);
    write_limit(13'd0);
    send_item(CMD_SAMPLE, pick_temp(1'b0), 4'd0);
    write_limit(13'd8191);
    send_item(CMD_SAMPLE, pick_temp(1'b0), 4'd0);
    write_limit(13'd2);
    repeat (2) send_item(CMD_SAMPLE, pick_temp(1'b0), 4'd0);
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < $size(PHASE_LIMITS); p++) begin
      write_limit(PHASE_LIMITS[p]);
      gap_max   = (p % 4 == 1) ? 0 : $urandom_range(6, 1);
      stall_pct = (p % 4 == 2) ? 0 : $urandom_range(70, 10);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(99) < 70)
          send_item(CMD_SAMPLE, pick_temp(1'b1), INDEX_W'($urandom()));
        else
          send_item(CMD_READ, SAMPLE_W'($urandom()), INDEX_W'($urandom()));
      end
    end
  endtask

  task automatic test_backpressure();
    wait_results();
    stall_pct = 0;
    gap_max   = 0;
    -> hold_ev;
    repeat (20) send_item(CMD_SAMPLE, pick_temp(1'b1), INDEX_W'($urandom()));
    wait_results();
    repeat (6) send_item(CMD_READ, SAMPLE_W'($urandom()), INDEX_W'($urandom_range(9)));
    wait_results();
  endtask

  task automatic test_window_capacity();
    stall_pct = 10;
    gap_max   = 2;
    // full window of the largest sample, then shrink it sample by sample
    write_limit(13'd20);
    repeat (24) send_item(CMD_SAMPLE, 16'sh7FFF, 4'd0);
    send_item(CMD_READ, 16'sd0, 4'd9);
    write_limit(13'd0);
    repeat (24) begin
      if ($urandom_range(7) == 0)
        send_item(CMD_READ, SAMPLE_W'($urandom()), INDEX_W'($urandom()));
      else
        send_item(CMD_SAMPLE, pick_temp(1'b0), INDEX_W'($urandom()));
    end
  endtask

  initial begin
    clear_stats();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_extremes();
    test_recent_wrap();
    test_window_limit();
    test_random_traffic();
    test_backpressure();
    test_window_capacity();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/wts_pkg.sv
hw/rtl/wts_front.sv
hw/rtl/wts_queue.sv
hw/rtl/wts_div.sv
hw/rtl/wts_back.sv
hw/rtl/windowed_temperature_statistics_unit.sv
tb/tb_top.sv
